@@ rtl/spcd_pkg.sv @@
// Shared types and constants for the stereo pop/click detector.
// No dependencies; imported by every module of the block.
package spcd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OFFSET_W = 16;
  localparam int GAIN_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // neighbor range (17 bits) plus offset gives 18 bits, shifted by up to 7
  localparam int RANGE_W = SAMPLE_W + 1;
  localparam int BASE_W  = SAMPLE_W + 2;
  localparam int DEV_W   = BASE_W + (1 << GAIN_W) - 1;
  localparam int CMP_W   = DEV_W + 2;

  localparam int SIDE_DEFAULT = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(120);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT = CFG_IDX_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t smp_l;
    sample_t smp_r;
    logic    er_l;
    logic    er_r;
  } slot_t;

  // handshake control from the top level into the window
  typedef struct packed {
    logic accept;
    logic advance;
  } pipe_ctl_t;

endpackage

@@ rtl/spcd_minmax.sv @@
// Registered-free max/min reduction tree over N signed samples.
// Depends on spcd_pkg for the sample type.
module spcd_minmax #(
  parameter int N = 2 * spcd_pkg::SIDE_DEFAULT
) (
  input  spcd_pkg::sample_t vals [N],
  output spcd_pkg::sample_t max_o,
  output spcd_pkg::sample_t min_o
);
  import spcd_pkg::*;

  localparam int NP = 1 << $clog2(N);

  sample_t hi [1:2*NP-1];
  sample_t lo [1:2*NP-1];

  // pad unused leaves with the first value; it cannot move max or min
  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < N) begin : g_real
      assign hi[NP+i] = vals[i];
      assign lo[NP+i] = vals[i];
    end else begin : g_pad
      assign hi[NP+i] = vals[0];
      assign lo[NP+i] = vals[0];
    end
  end

  for (genvar j = 1; j < NP; j++) begin : g_node
    assign hi[j] = (hi[2*j] > hi[2*j+1]) ? hi[2*j] : hi[2*j+1];
    assign lo[j] = (lo[2*j] < lo[2*j+1]) ? lo[2*j] : lo[2*j+1];
  end

  assign max_o = hi[1];
  assign min_o = lo[1];

endmodule

@@ rtl/spcd_detect.sv @@
// Pop test for one channel: neighbor max/min, threshold, and compare.
// Depends on spcd_pkg and spcd_minmax.
module spcd_detect #(
  parameter int SIDE = spcd_pkg::SIDE_DEFAULT
) (
  input  spcd_pkg::sample_t                  nbr [2*SIDE],
  input  spcd_pkg::sample_t                  center,
  input  logic                               center_er,
  input  logic [spcd_pkg::OFFSET_W-1:0]      dev_offset,
  input  logic [spcd_pkg::GAIN_W-1:0]        gain_shift,
  output logic                               flag
);
  import spcd_pkg::*;

  sample_t                   nbr_max;
  sample_t                   nbr_min;
  logic [RANGE_W-1:0]        rng;
  logic [BASE_W-1:0]         base;
  logic [DEV_W-1:0]          dev;
  logic signed [BASE_W-1:0]  d_hi;
  logic signed [BASE_W-1:0]  d_lo;
  logic                      pop;

  spcd_minmax #(.N(2 * SIDE)) u_minmax (
    .vals  (nbr),
    .max_o (nbr_max),
    .min_o (nbr_min)
  );

  always_comb begin
    rng  = RANGE_W'($signed({nbr_max[SAMPLE_W-1], nbr_max}) -
                    $signed({nbr_min[SAMPLE_W-1], nbr_min}));
    base = BASE_W'(rng) + BASE_W'(dev_offset);
    dev  = DEV_W'(base) << gain_shift;
    d_hi = BASE_W'(center) - BASE_W'(nbr_max);
    d_lo = BASE_W'(nbr_min) - BASE_W'(center);
    pop  = ($signed(CMP_W'(d_hi)) > $signed({2'b00, dev})) ||
           ($signed(CMP_W'(d_lo)) > $signed({2'b00, dev}));
    flag = center_er | pop;
  end

endmodule

@@ rtl/spcd_window.sv @@
// Sample window shift register with fill counter and pending-center flag.
// Depends on spcd_pkg.
module spcd_window #(
  parameter int SIDE = spcd_pkg::SIDE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spcd_pkg::pipe_ctl_t ctl,
  input  spcd_pkg::slot_t     in_slot,
  output spcd_pkg::slot_t     win [2*SIDE+1],
  output logic                pend
);
  import spcd_pkg::*;

  localparam int WIN_LEN = 2 * SIDE + 1;
  localparam int FILL_W  = $clog2(SIDE + 1);

  slot_t              win_r [WIN_LEN];
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_nxt;
  logic               pend_r;
  logic               pend_nxt;

  always_comb begin
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    if (ctl.accept) begin
      // a center is ready once SIDE earlier items sit in front of the new one
      pend_nxt = (fill_r == FILL_W'(SIDE));
      if (fill_r != FILL_W'(SIDE)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end else if (ctl.advance) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      if (ctl.accept) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_LEN-1] <= in_slot;
      end
    end
  end

  assign win  = win_r;
  assign pend = pend_r;

endmodule

@@ rtl/stereo_pop_click_detector.sv @@
// Stereo pop/click detector: sliding window of 2*SIDE+1 sample pairs,
// per-channel outlier test against neighbor max/min.
// Usage:
//   Input channel (in_valid / in_stall): one stereo pair with erasure flags
//   per transfer. Result channel (out_valid / out_stall): the pair taken SIDE
//   transfers earlier, values unchanged, flags set if already erased or if a
//   pop was found. The first SIDE input transfers after reset give no result.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   the deviation offset, index 1 the gain shift; write only while idle.
// Result path: after the transfer of sample k+SIDE, the result for sample k
//   passes the window register, then the detect compare into the output
//   register, once that is free; the receiver takes it when out_stall is low.
// Throughput: one item per cycle while out_stall is low; the window-to-output
//   compare path is a single stage, so a transfer can then happen on every clock.
// Reset: window cleared to zero samples with flags clear, fill count zero,
//   offset 120, gain shift 2.
// Stall: with the output register full and stalled, one more item is still
//   taken; in_stall rises only when a computed center is also waiting.
// Depends on spcd_pkg, spcd_window, spcd_detect, spcd_minmax.
module stereo_pop_click_detector #(
  parameter int SIDE = spcd_pkg::SIDE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  spcd_pkg::sample_t                  in_left_sample,
  input  spcd_pkg::sample_t                  in_right_sample,
  input  logic                               in_left_erased,
  input  logic                               in_right_erased,
  output logic                               out_valid,
  input  logic                               out_stall,
  output spcd_pkg::sample_t                  out_left_out,
  output spcd_pkg::sample_t                  out_right_out,
  output logic                               out_left_flag,
  output logic                               out_right_flag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import spcd_pkg::*;

  localparam int WIN_LEN = 2 * SIDE + 1;

  slot_t              in_slot;
  slot_t              win [WIN_LEN];
  pipe_ctl_t          ctl;
  logic               pend;
  logic               out_free;
  sample_t            nbr_l [2*SIDE];
  sample_t            nbr_r [2*SIDE];
  slot_t              ctr;
  logic               flag_l;
  logic               flag_r;

  logic [OFFSET_W-1:0] dev_offset_r;
  logic [GAIN_W-1:0]   gain_shift_r;

  logic     out_valid_r;
  logic     out_valid_nxt;
  sample_t  out_left_r;
  sample_t  out_right_r;
  logic     out_lflag_r;
  logic     out_rflag_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_offset_r <= OFFSET_RESET;
      gain_shift_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEV_OFFSET: dev_offset_r <= cfg_data[OFFSET_W-1:0];
        CFG_GAIN_SHIFT: gain_shift_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free    = !out_valid_r || !out_stall;
  assign ctl.advance = pend && out_free;
  assign in_stall    = pend && !out_free;
  assign ctl.accept  = in_valid && !in_stall;

  assign in_slot.smp_l = in_left_sample;
  assign in_slot.smp_r = in_right_sample;
  assign in_slot.er_l  = in_left_erased;
  assign in_slot.er_r  = in_right_erased;

  spcd_window #(.SIDE(SIDE)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_slot (in_slot),
    .win     (win),
    .pend    (pend)
  );

  // neighbors: SIDE before the center and SIDE after it
  for (genvar i = 0; i < SIDE; i++) begin : g_nbr
    assign nbr_l[i]        = win[i].smp_l;
    assign nbr_r[i]        = win[i].smp_r;
    assign nbr_l[SIDE + i] = win[SIDE + 1 + i].smp_l;
    assign nbr_r[SIDE + i] = win[SIDE + 1 + i].smp_r;
  end

  assign ctr = win[SIDE];

  spcd_detect #(.SIDE(SIDE)) u_detect_l (
    .nbr        (nbr_l),
    .center     (ctr.smp_l),
    .center_er  (ctr.er_l),
    .dev_offset (dev_offset_r),
    .gain_shift (gain_shift_r),
    .flag       (flag_l)
  );

  spcd_detect #(.SIDE(SIDE)) u_detect_r (
    .nbr        (nbr_r),
    .center     (ctr.smp_r),
    .center_er  (ctr.er_r),
    .dev_offset (dev_offset_r),
    .gain_shift (gain_shift_r),
    .flag       (flag_r)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_left_r  <= ctr.smp_l;
      out_right_r <= ctr.smp_r;
      out_lflag_r <= flag_l;
      out_rflag_r <= flag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_out   = out_left_r;
  assign out_right_out  = out_right_r;
  assign out_left_flag  = out_lflag_r;
  assign out_right_flag = out_rflag_r;

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pend && out_valid_r && out_stall))
    else $error("input stalled without a blocked pending center");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance |=> out_valid_r)
    else $error("output register empty after a center advanced");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend))
    else $error("result appeared with no pending center");
`endif

endmodule

@@ tb/stereo_pop_click_detector_tb.sv @@
`timescale 1ns / 100ps
// Testbench for stereo_pop_click_detector: a directed table, then random settings phases.
// Results are checked against this file's window model or typed-in rows, some under idle/stall.
// Depends on spcd_pkg and the stereo_pop_click_detector RTL.
module stereo_pop_click_detector_tb;
  import spcd_pkg::*;

  localparam int SIDE        = SIDE_DEFAULT;
  localparam int WIN_LEN     = 2 * SIDE;
  localparam int PHASE_ITEMS = 100;
  localparam int STUCK_LIMIT = 4000;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    slot_t stim;
    logic  typed_in;
    slot_t want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               in_left_sample = '0;
  sample_t               in_right_sample = '0;
  logic                  in_left_erased = 1'b0;
  logic                  in_right_erased = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               out_left_out;
  sample_t               out_right_out;
  logic                  out_left_flag;
  logic                  out_right_flag;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // travels with the payload: a typed-in expectation replaces the predicted one
  logic  row_typed = 1'b0;
  slot_t row_want = '0;

  // window model state
  slot_t               history [0:WIN_LEN-1];
  int                  fill_seen;
  logic [OFFSET_W-1:0] cur_offset;
  logic [GAIN_W-1:0]   cur_gain;
  slot_t               delayed_q [$];

  table_row_t directed_rows [$];
  int send_pct = 0;
  int rcv_pct = 0;
  int base_level = 0;
  int noise_span = 16;
  int mismatches = 0;
  int results_seen = 0;
  int items_taken = 0;
  int pops_found = 0;
  int cfg_writes = 0;
  int phases_run = 0;
  int stuck_cycles = 0;

  stereo_pop_click_detector uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .in_left_erased (in_left_erased),
    .in_right_erased(in_right_erased),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .out_left_flag  (out_left_flag),
    .out_right_flag (out_right_flag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sample_t clamp_sample(input int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  // outlier test for one channel; the center entry is left out of max/min
  function automatic logic pop_above_threshold(input logic [WIN_LEN:0][SAMPLE_W-1:0] s);
    int     hi;
    int     lo;
    int     c;
    int     v;
    longint dev;
    hi = $signed(s[0]);
    lo = hi;
    c = $signed(s[SIDE]);
    for (int i = 0; i <= WIN_LEN; i++) begin
      if (i != SIDE) begin
        v = $signed(s[i]);
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
    end
    dev = (longint'(hi) - longint'(lo) + longint'(cur_offset)) * (longint'(1) << cur_gain);
    return (longint'(c) - hi > dev) || (longint'(lo) - c > dev);
  endfunction

  task automatic shift_in_pair(input slot_t incoming, output logic made, output slot_t center);
    slot_t                        w [0:WIN_LEN];
    logic [WIN_LEN:0][SAMPLE_W-1:0] lch;
    logic [WIN_LEN:0][SAMPLE_W-1:0] rch;
    for (int i = 0; i < WIN_LEN; i++) w[i] = history[i];
    w[WIN_LEN] = incoming;
    for (int i = 0; i <= WIN_LEN; i++) begin
      lch[i] = w[i].smp_l;
      rch[i] = w[i].smp_r;
    end
    made = 1'b0;
    center = '0;
    if (fill_seen >= SIDE) begin
      made = 1'b1;
      center = w[SIDE];
      if (!center.er_l && pop_above_threshold(lch)) begin
        center.er_l = 1'b1;
        pops_found++;
      end
      if (!center.er_r && pop_above_threshold(rch)) begin
        center.er_r = 1'b1;
        pops_found++;
      end
    end else begin
      fill_seen++;
    end
    for (int i = 0; i < WIN_LEN; i++) history[i] = w[i + 1];
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
               $time, field, results_seen, got, want);
  endtask

  // check results against the oldest expectation, then predict for the new transfer
  always @(posedge clk) begin : monitor
    slot_t incoming;
    slot_t center;
    slot_t want;
    logic  made;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (delayed_q.size() == 0) begin
          report_mismatch("unexpected result, left_out", $signed(out_left_out), 0);
        end else begin
          want = delayed_q.pop_front();
          if (out_left_out !== want.smp_l)
            report_mismatch("left_out", $signed(out_left_out), $signed(want.smp_l));
          if (out_right_out !== want.smp_r)
            report_mismatch("right_out", $signed(out_right_out), $signed(want.smp_r));
          if (out_left_flag !== want.er_l)
            report_mismatch("left_flag", out_left_flag, want.er_l);
          if (out_right_flag !== want.er_r)
            report_mismatch("right_flag", out_right_flag, want.er_r);
        end
      end
      if (in_valid && !in_stall) begin
        incoming.smp_l = in_left_sample;
        incoming.smp_r = in_right_sample;
        incoming.er_l = in_left_erased;
        incoming.er_r = in_right_erased;
        shift_in_pair(incoming, made, center);
        if (made) delayed_q.push_back(row_typed ? row_want : center);
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer on any channel for %0d cycles", STUCK_LIMIT);
      $display("** stereo_pop_click_detector: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < rcv_pct);

  task automatic send_pair(input slot_t p, input logic typed_in, input slot_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_left_sample <= p.smp_l;
    in_right_sample <= p.smp_r;
    in_left_erased <= p.er_l;
    in_right_erased <= p.er_r;
    row_typed <= typed_in;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every expected pair is out, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DEV_OFFSET) cur_offset = data;
    else if (idx == CFG_GAIN_SHIFT) cur_gain = data[GAIN_W-1:0];
    cfg_writes++;
  endtask

  task automatic add_row(input int l, input int r, input logic el, input logic er,
                         input logic typed_in, input int wl, input int wr,
                         input logic wel, input logic wer);
    table_row_t row;
    row.stim.smp_l = sample_t'(l);
    row.stim.smp_r = sample_t'(r);
    row.stim.er_l = el;
    row.stim.er_r = er;
    row.typed_in = typed_in;
    row.want.smp_l = sample_t'(wl);
    row.want.smp_r = sample_t'(wr);
    row.want.er_l = wel;
    row.want.er_r = wer;
    directed_rows.push_back(row);
  endtask

  // mostly quiet audio drifting around a base, with spikes and some full-range noise
  function automatic slot_t random_pair();
    slot_t p;
    int    pick;
    int    mag;
    pick = $urandom_range(99);
    base_level = clamp_sample(base_level + int'($urandom_range(64)) - 32);
    p.smp_l = clamp_sample(base_level + int'($urandom_range(2 * noise_span)) - noise_span);
    p.smp_r = clamp_sample(base_level + int'($urandom_range(2 * noise_span)) - noise_span);
    if (pick < 10) begin
      p.smp_l = sample_t'($urandom);
      p.smp_r = sample_t'($urandom);
    end else if (pick < 30) begin
      mag = int'($urandom_range(4000));
      if ($urandom_range(1) != 0) mag = -mag;
      if ($urandom_range(2) != 0) p.smp_l = clamp_sample(p.smp_l + mag);
      if ($urandom_range(2) != 0) p.smp_r = clamp_sample(p.smp_r + mag);
    end
    p.er_l = ($urandom_range(11) == 0);
    p.er_r = ($urandom_range(11) == 0);
    return p;
  endfunction

  task automatic run_phase(input logic [OFFSET_W-1:0] offset, input logic [GAIN_W-1:0] gain,
                           input int sp, input int rp, input logic hold_mid);
    drain_results();
    write_reg(CFG_DEV_OFFSET, offset);
    write_reg(CFG_GAIN_SHIFT, CFG_DATA_W'(gain));
    send_pct = sp;
    rcv_pct = rp;
    base_level = int'($urandom_range(65535)) - 32768;
    noise_span = $urandom_range(4, 200);
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (hold_mid && n == PHASE_ITEMS / 2) drain_results();
      send_pair(random_pair(), 1'b0, '0);
    end
    phases_run++;
  endtask

  initial begin
    for (int i = 0; i < WIN_LEN; i++) history[i] = '0;
    fill_seen = 0;
    cur_offset = OFFSET_RESET;
    cur_gain = GAIN_RESET;

    // start-up pairs give nothing; then the zero-seeded window comes out clean
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 0);
    // full-scale spike on both channels among flat neighbors
    add_row(32767, -32768, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 32767, -32768, 1, 1);
    // flags set upstream pass through untouched
    add_row(0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(-32768, 32767, 1, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, -32768, 32767, 1, 1);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    // exactly on the threshold, then one past it
    add_row(480, -480, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(481, -481, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 481, -481, 1, 1);
    // non-zero neighbor range widens the threshold
    add_row(100, -100, 0, 0, 0, 0, 0, 0, 0);
    add_row(-100, 100, 0, 0, 0, 0, 0, 0, 0);
    add_row(1381, -1381, 0, 0, 0, 0, 0, 0, 0);
    add_row(100, -100, 0, 0, 0, 0, 0, 0, 0);
    add_row(-100, 100, 0, 0, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_pair(directed_rows[k].stim, directed_rows[k].typed_in, directed_rows[k].want);

    run_phase(16'd0, 3'd0, 0, 0, 1'b0);
    run_phase(16'hFFFF, 3'd7, 79, 0, 1'b0);
    run_phase(OFFSET_W'($urandom_range(65535)), 3'd4, 0, 79, 1'b0);
    run_phase(16'd0, 3'd4, 14, 14, 1'b1);
    run_phase(OFFSET_W'($urandom_range(400)), GAIN_W'($urandom_range(5, 7)), 0, 0, 1'b0);
    run_phase(16'd1, 3'd1, 79, 0, 1'b0);
    run_phase(OFFSET_W'($urandom_range(400)), 3'd3, 14, 14, 1'b0);

    drain_results();
    repeat (16) @(posedge clk);

    $display("Sent %0d sample pairs over %0d register settings (%0d writes), "
             , items_taken, phases_run + 1, cfg_writes);
    $display("checked %0d delayed pairs with %0d pops detected; %0d mismatches.",
             results_seen, pops_found, mismatches);
    if (mismatches == 0) begin
      $display("** stereo_pop_click_detector: PASSED **");
    end else begin
      $display("** stereo_pop_click_detector: FAILED **");
    end
    $finish;
  end

endmodule
